### hw/rtl/spe_pkg.sv
// Package for the shortest path engine: request and status codes, widths and defaults.
// Depends on nothing; used by shortest_path_engine.
package spe_pkg;
  localparam int unsigned DefMaxVertices = 32;
  localparam int unsigned DefMaxEdges    = 256;
  localparam logic [31:0] CostInf        = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_DIRECTED   = 2'd0,
    REQ_UNDIRECTED = 2'd1,
    REQ_QUERY      = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADSTART = 2'd3
  } status_t;
endpackage

### hw/rtl/shortest_path_engine.sv
// Shortest path engine: edge store in adjacency lists sorted by weight, and a
// single-source query over it. Depends on spe_pkg.
//
// One item at a time: busy is high from acceptance until the cycle in which its
// last result is shown, and a new item may be accepted at the edge that ends that
// cycle. Results cannot be held off; each appears for one cycle with out_valid.
// Ignored, rejected and unused requests pass through S_ACK, which registers their
// acknowledgement. An edge insert reads the source's list head, then reads and
// examines list entries in order until it finds a heavier one or the end, writes
// the new entry, patches the link of the entry before it when there is one, and
// does all this twice for an undirected edge, before its acknowledgement. A query
// clears its tables, then for each settled vertex runs a minimum search through
// the cost memory and handles each outgoing edge (read edge, read target cost,
// write back), runs one last search that finds nothing, and then shows one result
// per vertex.
module shortest_path_engine #(
  parameter int unsigned MAX_VERTICES = spe_pkg::DefMaxVertices,
  parameter int unsigned MAX_EDGES    = spe_pkg::DefMaxEdges
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_vertex_count,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_node_a,
  input  logic [5:0]  in_node_b,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_vertex,
  output logic [31:0] out_path_cost,
  output logic [5:0]  out_predecessor,
  output logic        out_reachable,
  output logic        out_last
);
  import spe_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] NIL = CW'(MAX_EDGES);

  typedef enum logic [4:0] {
    S_IDLE, S_ACK, S_INS_HEAD, S_INS_RD, S_INS_CHK, S_INS_LINK, S_INS_PATCH,
    S_Q_CLR, S_Q_INIT, S_Q_SCAN, S_Q_SCAN_W, S_Q_PICK, S_Q_EDGE, S_Q_TGT,
    S_Q_RELAX, S_Q_OUT, S_Q_OUT_W
  } state_t;

  // Edge store memory (target, cost, next) and per-vertex memory (cost, prev, settled).
  logic [VW+16+CW-1:0] edge_mem [MAX_EDGES];
  logic [32+6+1-1:0]   vert_mem [MAX_VERTICES];
  logic [CW-1:0]       head_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_ok_r;

  logic [EW-1:0]       e_raddr;
  logic [VW+16+CW-1:0] e_rdata_r;
  logic                e_we;
  logic [EW-1:0]       e_waddr;
  logic [VW+16+CW-1:0] e_wdata;
  logic [VW-1:0]       v_raddr;
  logic [38:0]         v_rdata_r;
  logic                v_we;
  logic [VW-1:0]       v_waddr;
  logic [38:0]         v_wdata;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata_r <= edge_mem[e_raddr];
    if (v_we) begin
      vert_mem[v_waddr] <= v_wdata;
    end
    v_rdata_r <= vert_mem[v_raddr];
  end

  state_t          state_r;
  logic [5:0]      vcount_r;
  logic [CW-1:0]   used_r;
  logic [1:0]      req_r;
  logic [VW-1:0]   src_r, dst_r;
  logic [15:0]     w_r;
  logic            second_r;
  logic [CW-1:0]   cur_r, prv_r;
  logic [VW-1:0]   prv_tgt_r;
  logic [15:0]     prv_cost_r;
  logic [VW:0]     idx_r;
  logic [NW-1:0]   n_r;
  logic [VW-1:0]   scan_i_r;
  logic            scan_v_r;
  logic [VW-1:0]   pick_r;
  logic [31:0]     pick_cost_r;
  logic [5:0]      pick_prev_r;
  logic            found_r;
  logic [31:0]     base_r;
  logic [VW-1:0]   tgt_r;
  logic [15:0]     ew_r;
  logic            out_valid_r, out_last_r, out_reach_r;
  logic [1:0]      out_status_r;
  logic [5:0]      out_vertex_r, out_pred_r;
  logic [31:0]     out_cost_r;

  logic [NW-1:0] n_eff;
  always_comb begin
    if (vcount_r == 6'd0) begin
      n_eff = NW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_r);
    end
  end

  logic [VW:0] n_last;
  assign n_last = (VW+1)'(n_r) - (VW+1)'(1);

  logic a_ok, b_ok;
  assign a_ok = (in_node_a != 6'd0) && (32'(in_node_a) <= 32'(n_eff));
  assign b_ok = (in_node_b != 6'd0) && (32'(in_node_b) <= 32'(n_eff));

  logic [CW-1:0] head_src, head_pick;
  assign head_src  = head_ok_r[src_r] ? head_r[src_r] : NIL;
  assign head_pick = head_ok_r[pick_r] ? head_r[pick_r] : NIL;

  logic [VW-1:0] e_tgt;
  logic [15:0]   e_cost;
  logic [CW-1:0] e_next;
  assign {e_tgt, e_cost, e_next} = e_rdata_r;
  logic [31:0] v_cost;
  logic [5:0]  v_prev;
  logic        v_set;
  assign {v_cost, v_prev, v_set} = v_rdata_r;

  logic [32:0] sum;
  assign sum = {1'b0, base_r} + {17'd0, ew_r};
  logic [31:0] nc;
  assign nc = sum[32] ? CostInf : sum[31:0];

  logic better;
  assign better = scan_v_r && !v_set && (v_cost != CostInf) &&
                  (!found_r || (v_cost < pick_cost_r));

  logic out_fire;
  assign out_fire = (state_r == S_ACK) || (state_r == S_Q_OUT && scan_v_r) ||
                    (state_r == S_Q_OUT_W);

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_vertex      = out_vertex_r;
  assign out_path_cost   = out_cost_r;
  assign out_predecessor = out_pred_r;
  assign out_reachable   = out_reach_r;
  assign out_last        = out_last_r;

  // Memory port control.
  always_comb begin
    e_raddr = cur_r[EW-1:0];
    e_we    = 1'b0;
    e_waddr = used_r[EW-1:0];
    e_wdata = {dst_r, w_r, cur_r};
    v_raddr = idx_r[VW-1:0];
    v_we    = 1'b0;
    v_waddr = idx_r[VW-1:0];
    v_wdata = {CostInf, 6'd0, 1'b0};
    case (state_r)
      S_INS_LINK: begin
        e_we = 1'b1;
      end
      S_INS_PATCH: begin
        e_we    = 1'b1;
        e_waddr = prv_r[EW-1:0];
        e_wdata = {prv_tgt_r, prv_cost_r, used_r};
      end
      S_Q_CLR: begin
        v_we = 1'b1;
        if (idx_r[VW-1:0] == src_r) begin
          v_wdata = {32'd0, 6'd0, 1'b0};
        end
      end
      S_Q_PICK: begin
        v_we    = found_r;
        v_waddr = pick_r;
        v_wdata = {pick_cost_r, pick_prev_r, 1'b1};
      end
      S_Q_TGT: begin
        v_raddr = e_tgt;
      end
      S_Q_RELAX: begin
        v_waddr = tgt_r;
        v_we    = ({1'b0, tgt_r} < (VW+1)'(n_r)) && (nc < v_cost);
        v_wdata = {nc, 6'(32'(pick_r) + 32'd1), v_set};
      end
      default: ;
    endcase
  end

  // The new entry is written in S_INS_LINK; the predecessor's link, when there is
  // one, is patched in S_INS_PATCH.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 6'd32;
      used_r      <= '0;
      head_ok_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_fire;
      if (cfg_we) begin
        vcount_r <= cfg_vertex_count;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r    <= in_req_type;
            src_r    <= VW'(in_node_a - 6'd1);
            dst_r    <= VW'(in_node_b - 6'd1);
            w_r      <= in_edge_weight;
            second_r <= 1'b0;
            n_r      <= n_eff;
            idx_r    <= '0;
            out_status_r <= ST_OK;
            case (in_req_type)
              REQ_DIRECTED: begin
                if (!a_ok || !b_ok) begin
                  out_status_r <= ST_IGNORED;
                  state_r <= S_ACK;
                end else if (used_r == NIL) begin
                  out_status_r <= ST_FULL;
                  state_r <= S_ACK;
                end else begin
                  state_r <= S_INS_HEAD;
                end
              end
              REQ_UNDIRECTED: begin
                if (!a_ok || !b_ok || in_node_a == in_node_b) begin
                  out_status_r <= ST_IGNORED;
                  state_r <= S_ACK;
                end else if (32'(used_r) + 2 > MAX_EDGES) begin
                  out_status_r <= ST_FULL;
                  state_r <= S_ACK;
                end else begin
                  state_r <= S_INS_HEAD;
                end
              end
              REQ_QUERY: begin
                if (!a_ok) begin
                  out_status_r <= ST_BADSTART;
                  state_r <= S_ACK;
                end else begin
                  state_r <= S_Q_CLR;
                end
              end
              default: begin
                out_status_r <= ST_IGNORED;
                state_r <= S_ACK;
              end
            endcase
          end
        end
        S_ACK: begin
          state_r <= S_IDLE;
        end
        S_INS_HEAD: begin
          cur_r   <= head_src;
          prv_r   <= NIL;
          state_r <= S_INS_RD;
        end
        S_INS_RD: begin
          state_r <= (cur_r == NIL) ? S_INS_LINK : S_INS_CHK;
        end
        S_INS_CHK: begin
          if (e_cost <= w_r) begin
            prv_r      <= cur_r;
            prv_tgt_r  <= e_tgt;
            prv_cost_r <= e_cost;
            cur_r      <= e_next;
            state_r    <= S_INS_RD;
          end else begin
            state_r <= S_INS_LINK;
          end
        end
        S_INS_LINK: begin
          if (prv_r == NIL) begin
            head_r[src_r]    <= used_r;
            head_ok_r[src_r] <= 1'b1;
            used_r           <= used_r + CW'(1);
            if (req_r == REQ_UNDIRECTED && !second_r) begin
              second_r <= 1'b1;
              src_r    <= dst_r;
              dst_r    <= src_r;
              state_r  <= S_INS_HEAD;
            end else begin
              state_r <= S_ACK;
            end
          end else begin
            state_r <= S_INS_PATCH;
          end
        end
        S_INS_PATCH: begin
          used_r <= used_r + CW'(1);
          if (req_r == REQ_UNDIRECTED && !second_r) begin
            second_r <= 1'b1;
            src_r    <= dst_r;
            dst_r    <= src_r;
            state_r  <= S_INS_HEAD;
          end else begin
            state_r <= S_ACK;
          end
        end
        S_Q_CLR: begin
          idx_r <= idx_r + (VW+1)'(1);
          if (idx_r == n_last) begin
            state_r <= S_Q_INIT;
          end
        end
        S_Q_INIT: begin
          idx_r    <= '0;
          found_r  <= 1'b0;
          scan_v_r <= 1'b0;
          state_r  <= S_Q_SCAN;
        end
        S_Q_SCAN: begin
          if (better) begin
            found_r     <= 1'b1;
            pick_r      <= scan_i_r;
            pick_cost_r <= v_cost;
            pick_prev_r <= v_prev;
          end
          scan_i_r <= idx_r[VW-1:0];
          scan_v_r <= 1'b1;
          idx_r    <= idx_r + (VW+1)'(1);
          if (idx_r == n_last) begin
            state_r <= S_Q_SCAN_W;
          end
        end
        S_Q_SCAN_W: begin
          if (better) begin
            found_r     <= 1'b1;
            pick_r      <= scan_i_r;
            pick_cost_r <= v_cost;
            pick_prev_r <= v_prev;
          end
          state_r <= S_Q_PICK;
        end
        S_Q_PICK: begin
          if (!found_r) begin
            idx_r    <= '0;
            scan_v_r <= 1'b0;
            state_r  <= S_Q_OUT;
          end else begin
            base_r  <= pick_cost_r;
            cur_r   <= head_pick;
            state_r <= (head_pick == NIL) ? S_Q_INIT : S_Q_EDGE;
          end
        end
        S_Q_EDGE: begin
          state_r <= S_Q_TGT;
        end
        S_Q_TGT: begin
          tgt_r   <= e_tgt;
          ew_r    <= e_cost;
          cur_r   <= e_next;
          state_r <= S_Q_RELAX;
        end
        S_Q_RELAX: begin
          state_r <= (cur_r == NIL) ? S_Q_INIT : S_Q_EDGE;
        end
        S_Q_OUT: begin
          scan_i_r <= idx_r[VW-1:0];
          scan_v_r <= 1'b1;
          idx_r    <= idx_r + (VW+1)'(1);
          if (idx_r == n_last) begin
            state_r <= S_Q_OUT_W;
          end
        end
        S_Q_OUT_W: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_ACK) begin
        out_vertex_r <= 6'd0;
        out_cost_r   <= (out_status_r == ST_BADSTART) ? CostInf : 32'd0;
        out_pred_r   <= 6'd0;
        out_reach_r  <= 1'b0;
        out_last_r   <= 1'b1;
      end else if (out_fire) begin
        out_vertex_r <= 6'(32'(scan_i_r) + 32'd1);
        out_cost_r   <= v_cost;
        out_pred_r   <= v_prev;
        out_reach_r  <= v_set;
        out_last_r   <= ({1'b0, scan_i_r} == n_last);
      end
    end
  end

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid);
  a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy);
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NIL);
  a_query_rows_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_OK));
endmodule
